@@ sv/assert_macros.svh @@
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

@@ sv/kirm_pkg.sv @@
package kirm_pkg;
   localparam int MAX_OLD = 64;
   localparam int MAX_NEW = 64;
   localparam int LEVEL_BITS = 8;
   localparam int OLD_AW = $clog2(MAX_OLD);
   localparam int NEW_AW = $clog2(MAX_NEW);
   localparam int OCW = $clog2(MAX_OLD + 1);
   localparam int NCW = $clog2(MAX_NEW + 1);

   localparam logic [1:0] CMD_LOAD_OLD = 2'd0;
   localparam logic [1:0] CMD_LOAD_NEW = 2'd1;
   localparam logic [1:0] CMD_FETCH    = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam logic [2:0] KIND_ACCEPTED = 3'd0;
   localparam logic [2:0] KIND_RECORD   = 3'd1;
   localparam logic [2:0] KIND_COUNTS   = 3'd2;
   localparam logic [2:0] KIND_OLD_BAD  = 3'd3;
   localparam logic [2:0] KIND_NEW_BAD  = 3'd4;
   localparam logic [2:0] KIND_FULL     = 3'd5;

   localparam logic [1:0] OUT_REUSED  = 2'd0;
   localparam logic [1:0] OUT_CHANGED = 2'd1;
   localparam logic [1:0] OUT_NEWKEY  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  level;
      logic [63:0] locator;
      logic [63:0] body_hash;
      logic [63:0] deps_hash;
      logic [63:0] macro_env_hash;
      logic [63:0] template_env_hash;
      logic        macro_flag;
      logic        template_flag;
      logic [63:0] old_identity;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_level;
      logic [63:0] out_locator;
      logic [63:0] identity;
      logic [1:0]  outcome;
      logic [6:0]  total_count;
      logic [6:0]  reused_count;
      logic [6:0]  invalidated_count;
      logic [6:0]  created_count;
      logic        last;
   } rsp_type;

   // stored record: key, hashes, flags, identity
   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic [63:0] locator;
      logic [63:0] chash;
      logic [63:0] dhash;
      logic [63:0] menv;
      logic [63:0] tenv;
      logic        mflag;
      logic        tflag;
      logic [63:0] ident;
   } rec_type;

   localparam int KEY_W = LEVEL_BITS + 64;

   function automatic logic [KEY_W-1:0] key_of(rec_type r);
      return {r.level, r.locator};
   endfunction
endpackage

@@ sv/kirm_ram.sv @@
module kirm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ sv/keyed_identity_reuse_matcher.sv @@
// channel | dir | payload  | handshake
// req     | in  | req_type | req_valid / req_ready
// rsp     | out | rsp_type | rsp_valid / rsp_ready
// a load walks the store from the top down, shifting each greater entry up one place
// (read then write on one ram port pair)
// a fetch scans the old store one entry per cycle
// reset is synchronous, no clearing pass
// req_ready is low while an item is in work or a result waits for rsp_ready
`include "assert_macros.svh"
module keyed_identity_reuse_matcher import kirm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int RW = $bits(rec_type);
   localparam int AW = (OLD_AW > NEW_AW) ? OLD_AW : NEW_AW;
   localparam int CW = (OCW > NCW) ? OCW : NCW;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_SRD   = 8'b00000010,
      ST_SCMP  = 8'b00000100,
      ST_FRD   = 8'b00001000,
      ST_FWAIT = 8'b00010000,
      ST_FCMP  = 8'b00100000,
      ST_ORD   = 8'b01000000,
      ST_RESP  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   rec_type   e_ff, e_in, c_ff, c_in;
   logic      sel_new_ff, sel_new_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic      dup_ff, dup_in;
   logic [OCW-1:0] old_count_ff, old_count_in;
   logic [NCW-1:0] new_count_ff, new_count_in;
   logic [63:0] fresh_ff, fresh_in;
   logic [1:0]  err_ff, err_in;
   logic [NCW-1:0] fetch_ff, fetch_in;
   logic [6:0] reu_ff, reu_in, inv_ff, inv_in, cre_ff, cre_in;
   rsp_type rsp_ff, rsp_in;
   logic    clear;

   logic          o_we, n_we;
   logic [OLD_AW-1:0] o_wa, o_ra;
   logic [NEW_AW-1:0] n_wa, n_ra;
   rec_type o_wd, n_wd, o_rd, n_rd, mem_rd, wr_rec;
   logic    wr_en;
   logic [AW-1:0] wr_a, rd_a;

   kirm_ram #(.DEPTH(MAX_OLD), .WIDTH(RW)) u_old (
      .clock, .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd), .rd_addr(o_ra), .rd_data(o_rd));
   kirm_ram #(.DEPTH(MAX_NEW), .WIDTH(RW)) u_new (
      .clock, .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd), .rd_addr(n_ra), .rd_data(n_rd));

   assign o_we = wr_en && !sel_new_ff;
   assign n_we = wr_en && sel_new_ff;
   assign o_wa = OLD_AW'(wr_a);
   assign n_wa = NEW_AW'(wr_a);
   assign o_wd = wr_rec;
   assign n_wd = wr_rec;
   assign o_ra = OLD_AW'(rd_a);
   assign n_ra = NEW_AW'(rd_a);
   assign mem_rd = sel_new_ff ? n_rd : o_rd;

   function automatic logic [6:0] sat7(logic [CW:0] v);
      return (v > (CW+1)'(127)) ? 7'd127 : 7'(v);
   endfunction

   function automatic logic reusable(rec_type p, rec_type c);
      logic ok;
      ok = (p.chash == c.chash) && (p.dhash == c.dhash) &&
           (p.mflag == c.mflag) && (p.tflag == c.tflag);
      if (c.mflag && (c.menv == 64'd0 || p.menv != c.menv)) ok = 1'b0;
      if (c.tflag && (c.tenv == 64'd0 || p.tenv != c.tenv)) ok = 1'b0;
      return ok;
   endfunction

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   always_comb begin
      rec_type r;
      logic bad;
      state_in = state_ff;
      e_in = e_ff; c_in = c_ff; sel_new_in = sel_new_ff; idx_in = idx_ff; dup_in = dup_ff;
      old_count_in = old_count_ff; new_count_in = new_count_ff; fresh_in = fresh_ff;
      err_in = err_ff; fetch_in = fetch_ff; reu_in = reu_ff; inv_in = inv_ff; cre_in = cre_ff;
      rsp_in = rsp_ff; clear = 1'b0;
      wr_en = 1'b0; wr_a = '0; wr_rec = e_ff; rd_a = '0;
      r = '0;
      bad = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               r.level = LEVEL_BITS'(req_data.level);
               r.locator = req_data.locator;
               r.chash = req_data.body_hash;
               r.dhash = req_data.deps_hash;
               r.menv = req_data.macro_env_hash;
               r.tenv = req_data.template_env_hash;
               r.mflag = req_data.macro_flag;
               r.tflag = req_data.template_flag;
               r.ident = req_data.old_identity;
               e_in = r;
               dup_in = 1'b0;
               rsp_in = '0;
               unique case (req_data.command)
                  CMD_LOAD_OLD, CMD_LOAD_NEW: begin
                     sel_new_in = (req_data.command == CMD_LOAD_NEW);
                     if (sel_new_in ? (new_count_ff >= NCW'(MAX_NEW))
                                    : (old_count_ff >= OCW'(MAX_OLD))) begin
                        clear = 1'b1;
                        rsp_in.kind = KIND_FULL;
                        rsp_in.last = 1'b1;
                        state_in = ST_RESP;
                     end else begin
                        idx_in = sel_new_in ? CW'(new_count_ff) : CW'(old_count_ff);
                        state_in = ST_SRD;
                     end
                  end
                  CMD_FETCH: begin
                     if (err_ff[0]) begin
                        clear = 1'b1; rsp_in.kind = KIND_OLD_BAD; rsp_in.last = 1'b1;
                        state_in = ST_RESP;
                     end else if (err_ff[1]) begin
                        clear = 1'b1; rsp_in.kind = KIND_NEW_BAD; rsp_in.last = 1'b1;
                        state_in = ST_RESP;
                     end else if (fetch_ff < new_count_ff) begin
                        sel_new_in = 1'b1;
                        state_in = ST_FRD;
                     end else begin
                        rsp_in.kind = KIND_COUNTS;
                        rsp_in.total_count = sat7((CW+1)'(new_count_ff));
                        rsp_in.reused_count = reu_ff;
                        rsp_in.invalidated_count = inv_ff;
                        rsp_in.created_count = cre_ff;
                        rsp_in.last = 1'b1;
                        clear = 1'b1;
                        state_in = ST_RESP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // insertion walk: idx is the hole; read idx-1, shift up if greater
         ST_SRD: begin
            if (idx_ff == '0) begin
               wr_en = 1'b1; wr_a = AW'(idx_ff); wr_rec = e_ff;
               state_in = ST_ORD;
            end else begin
               rd_a = AW'(idx_ff - CW'(1));
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (key_of(mem_rd) == key_of(e_ff)) dup_in = 1'b1;
            if (key_of(mem_rd) > key_of(e_ff)) begin
               wr_en = 1'b1; wr_a = AW'(idx_ff); wr_rec = mem_rd;
               idx_in = idx_ff - CW'(1);
               state_in = ST_SRD;
            end else begin
               wr_en = 1'b1; wr_a = AW'(idx_ff); wr_rec = e_ff;
               state_in = ST_ORD;
            end
         end
         // finish a load: stores sorted so only the neighbor below can match,
         // and one above never matches (greater); dup_ff covers the neighbor
         ST_ORD: begin
            if (sel_new_ff) begin
               new_count_in = new_count_ff + NCW'(1);
               bad = dup_ff || (e_ff.ident != 64'd0) || (e_ff.locator == 64'd0) ||
                     (e_ff.chash == 64'd0) || (e_ff.dhash == 64'd0);
               if (bad) err_in[1] = 1'b1;
            end else begin
               old_count_in = old_count_ff + OCW'(1);
               bad = dup_ff || (e_ff.ident == 64'd0) || (e_ff.locator == 64'd0) ||
                     (e_ff.chash == 64'd0) || (e_ff.dhash == 64'd0);
               if (bad) err_in[0] = 1'b1;
               if (e_ff.ident + 64'd1 > fresh_ff) fresh_in = e_ff.ident + 64'd1;
            end
            rsp_in.kind = KIND_ACCEPTED;
            state_in = ST_RESP;
         end
         ST_FRD: begin
            rd_a = AW'(fetch_ff);
            state_in = ST_FWAIT;
         end
         ST_FWAIT: begin
            c_in = mem_rd;
            sel_new_in = 1'b0;
            idx_in = '0;
            rd_a = '0;
            state_in = ST_FCMP;
         end
         // old store scan: mem_rd holds entry idx
         ST_FCMP: begin
            rsp_in.kind = KIND_RECORD;
            rsp_in.out_level = 8'(c_ff.level);
            rsp_in.out_locator = c_ff.locator;
            if (idx_ff < CW'(old_count_ff) && key_of(mem_rd) == key_of(c_ff)) begin
               if (reusable(mem_rd, c_ff)) begin
                  rsp_in.identity = mem_rd.ident; rsp_in.outcome = OUT_REUSED;
                  reu_in = reu_ff + 7'd1;
               end else begin
                  rsp_in.identity = fresh_ff; rsp_in.outcome = OUT_CHANGED;
                  fresh_in = fresh_ff + 64'd1;
                  inv_in = inv_ff + 7'd1; cre_in = cre_ff + 7'd1;
               end
               fetch_in = fetch_ff + NCW'(1);
               state_in = ST_RESP;
            end else if (idx_ff + CW'(1) >= CW'(old_count_ff) || idx_ff >= CW'(old_count_ff)) begin
               rsp_in.identity = fresh_ff; rsp_in.outcome = OUT_NEWKEY;
               fresh_in = fresh_ff + 64'd1;
               cre_in = cre_ff + 7'd1;
               fetch_in = fetch_ff + NCW'(1);
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + CW'(1);
               rd_a = AW'(idx_ff + CW'(1));
            end
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         old_count_ff <= '0; new_count_ff <= '0; fresh_ff <= 64'd1; err_ff <= '0;
         fetch_ff <= '0; reu_ff <= '0; inv_ff <= '0; cre_ff <= '0;
      end else begin
         old_count_ff <= old_count_in; new_count_ff <= new_count_in; fresh_ff <= fresh_in;
         err_ff <= err_in; fetch_ff <= fetch_in;
         reu_ff <= reu_in; inv_ff <= inv_in; cre_ff <= cre_in;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      e_ff <= e_in; c_ff <= c_in; sel_new_ff <= sel_new_in; idx_ff <= idx_in;
      dup_ff <= dup_in; rsp_ff <= rsp_in;
   end

   `ASSERT_CLK(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !req_ready, "ready while busy")
   `ASSERT_CLK(a_old_bound, clock, reset, old_count_ff <= OCW'(MAX_OLD), "old count overflow")
   `ASSERT_CLK(a_new_bound, clock, reset, new_count_ff <= NCW'(MAX_NEW), "new count overflow")
   `ASSERT_CLK(a_fetch_bound, clock, reset, fetch_ff <= new_count_ff, "fetch beyond store")
endmodule

@@ dv/keyed_identity_reuse_matcher_test.sv @@
`timescale 1ns / 1ps
module keyed_identity_reuse_matcher_test import kirm_pkg::*; ();

   localparam int LIMIT = 2000000;
   localparam int DRAIN_WAIT = 2 * MAX_OLD + 20;

   logic    clock = 0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   keyed_identity_reuse_matcher u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // predictor state: index 0 old set, 1 new set
   rec_type     rec_store [2][MAX_OLD];
   int          rec_cnt [2];
   logic [63:0] fresh_id;
   bit          old_bad, new_bad;
   int          walk_idx;
   int          n_reused, n_invalidated, n_created;

   rsp_type awaited_rsp [$];
   int send_idle, recv_idle;
   int beats_sent, fails, cycles;
   int seen_kind [6];

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("** keyed_identity_reuse_matcher: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic logic [63:0] r64();
      return {$urandom, $urandom};
   endfunction

   task automatic clear_session();
      rec_cnt[0] = 0;
      rec_cnt[1] = 0;
      fresh_id = 64'd1;
      old_bad = 0;
      new_bad = 0;
      walk_idx = 0;
      n_reused = 0;
      n_invalidated = 0;
      n_created = 0;
   endtask

   function automatic bit same_key(rec_type a, rec_type b);
      return a.level == b.level && a.locator == b.locator;
   endfunction

   function automatic bit key_above(rec_type a, rec_type b);
      return a.level > b.level || (a.level == b.level && a.locator > b.locator);
   endfunction

   // insert in key order, returns 1 when the key was already there
   task automatic insert_rec(input int s, input rec_type e, output bit dup);
      int pos;
      pos = rec_cnt[s];
      dup = 0;
      for (int i = 0; i < rec_cnt[s]; i++) begin
         if (same_key(rec_store[s][i], e)) dup = 1;
         if (key_above(rec_store[s][i], e) && pos == rec_cnt[s]) pos = i;
      end
      for (int i = rec_cnt[s]; i > pos; i--) rec_store[s][i] = rec_store[s][i-1];
      rec_store[s][pos] = e;
      rec_cnt[s]++;
   endtask

   function automatic bit can_reuse(rec_type p, rec_type c);
      if (p.chash != c.chash || p.dhash != c.dhash ||
          p.mflag != c.mflag || p.tflag != c.tflag) return 0;
      if (c.mflag && (c.menv == 0 || p.menv != c.menv)) return 0;
      if (c.tflag && (c.tenv == 0 || p.tenv != c.tenv)) return 0;
      return 1;
   endfunction

   task automatic match_predict(input req_type b);
      rec_type     e;
      rsp_type     r;
      bit          dup;
      int          hit;
      logic [63:0] nxt;
      r = '0;
      e.level = b.level;
      e.locator = b.locator;
      e.chash = b.body_hash;
      e.dhash = b.deps_hash;
      e.menv = b.macro_env_hash;
      e.tenv = b.template_env_hash;
      e.mflag = b.macro_flag;
      e.tflag = b.template_flag;
      e.ident = b.old_identity;
      case (b.command)
         CMD_LOAD_OLD, CMD_LOAD_NEW: begin
            if (rec_cnt[b.command == CMD_LOAD_NEW] >=
                ((b.command == CMD_LOAD_NEW) ? MAX_NEW : MAX_OLD)) begin
               clear_session();
               r.kind = KIND_FULL;
               r.last = 1'b1;
            end else if (b.command == CMD_LOAD_OLD) begin
               insert_rec(0, e, dup);
               if (dup || e.ident == 0 || e.locator == 0 || e.chash == 0 || e.dhash == 0)
                  old_bad = 1;
               nxt = e.ident + 64'd1;
               if (nxt > fresh_id) fresh_id = nxt;
               r.kind = KIND_ACCEPTED;
            end else begin
               insert_rec(1, e, dup);
               if (dup || e.ident != 0 || e.locator == 0 || e.chash == 0 || e.dhash == 0)
                  new_bad = 1;
               r.kind = KIND_ACCEPTED;
            end
         end
         CMD_FETCH: begin
            if (old_bad) begin
               clear_session();
               r.kind = KIND_OLD_BAD;
               r.last = 1'b1;
            end else if (new_bad) begin
               clear_session();
               r.kind = KIND_NEW_BAD;
               r.last = 1'b1;
            end else if (walk_idx < rec_cnt[1]) begin
               e = rec_store[1][walk_idx];
               hit = -1;
               for (int i = 0; i < rec_cnt[0]; i++)
                  if (hit < 0 && same_key(rec_store[0][i], e)) hit = i;
               r.kind = KIND_RECORD;
               r.out_level = e.level;
               r.out_locator = e.locator;
               if (hit >= 0 && can_reuse(rec_store[0][hit], e)) begin
                  r.identity = rec_store[0][hit].ident;
                  r.outcome = OUT_REUSED;
                  n_reused++;
               end else begin
                  r.identity = fresh_id;
                  fresh_id = fresh_id + 64'd1;
                  r.outcome = (hit >= 0) ? OUT_CHANGED : OUT_NEWKEY;
                  if (hit >= 0) n_invalidated++;
                  n_created++;
               end
               walk_idx++;
            end else begin
               r.kind = KIND_COUNTS;
               r.total_count = 7'(rec_cnt[1]);
               r.reused_count = 7'(n_reused);
               r.invalidated_count = 7'(n_invalidated);
               r.created_count = 7'(n_created);
               r.last = 1'b1;
               clear_session();
            end
         end
         default: return;
      endcase
      awaited_rsp.push_back(r);
   endtask

   task automatic check_beat(input rsp_type x, input rsp_type a);
      if (a.kind != x.kind)
         $error("kind exp %0d got %0d", x.kind, a.kind);
      if (a.out_level != x.out_level)
         $error("out_level exp %0d got %0d", x.out_level, a.out_level);
      if (a.out_locator != x.out_locator)
         $error("out_locator exp %h got %h", x.out_locator, a.out_locator);
      if (a.identity != x.identity)
         $error("identity exp %h got %h", x.identity, a.identity);
      if (a.outcome != x.outcome)
         $error("outcome exp %0d got %0d", x.outcome, a.outcome);
      if (a.total_count != x.total_count)
         $error("total_count exp %0d got %0d", x.total_count, a.total_count);
      if (a.reused_count != x.reused_count)
         $error("reused_count exp %0d got %0d", x.reused_count, a.reused_count);
      if (a.invalidated_count != x.invalidated_count)
         $error("invalidated_count exp %0d got %0d", x.invalidated_count,
                a.invalidated_count);
      if (a.created_count != x.created_count)
         $error("created_count exp %0d got %0d", x.created_count, a.created_count);
      if (a.last != x.last)
         $error("last exp %0d got %0d", x.last, a.last);
      if (a != x) fails++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected result beat kind %0d", rsp_data.kind);
            fails++;
         end else begin
            check_beat(awaited_rsp.pop_front(), rsp_data);
            if (rsp_data.kind < 6) seen_kind[rsp_data.kind]++;
         end
      end
   end

   task automatic send_beat(input req_type b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      match_predict(b);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic req_type make_rec(logic [1:0] cmd, logic [7:0] lvl, logic [63:0] loc,
                                        logic [63:0] id);
      req_type b;
      b.command = cmd;
      b.level = lvl;
      b.locator = loc;
      b.body_hash = r64() | 64'd1;
      b.deps_hash = r64() | 64'd1;
      b.macro_env_hash = r64();
      b.template_env_hash = r64();
      b.macro_flag = 1'($urandom_range(1));
      b.template_flag = 1'($urandom_range(1));
      b.old_identity = id;
      return b;
   endfunction

   function automatic req_type fetch_beat();
      req_type b;
      b = '0;
      b.command = CMD_FETCH;
      return b;
   endfunction

   task automatic test_reuse_outcomes();
      req_type a, c, d, n;
      a = make_rec(CMD_LOAD_OLD, 8'd0, 64'd1, 64'hffff_ffff_ffff_ffff);
      a.macro_flag = 1;
      a.template_flag = 1;
      a.body_hash = '1;
      a.deps_hash = '1;
      a.macro_env_hash = '1;
      a.template_env_hash = '1;
      c = make_rec(CMD_LOAD_OLD, 8'd255, '1, 64'd7);
      d = make_rec(CMD_LOAD_OLD, 8'd5, 64'd7, 64'd100);
      d.macro_flag = 1;
      d.macro_env_hash = 64'd0;
      send_beat(c);
      send_beat(a);
      send_beat(d);
      n = a;
      n.command = CMD_LOAD_NEW;
      n.old_identity = 0;
      send_beat(n);
      n = c;
      n.command = CMD_LOAD_NEW;
      n.old_identity = 0;
      n.body_hash = c.body_hash ^ 64'h8000_0000_0000_0000;
      send_beat(n);
      n = d;
      n.command = CMD_LOAD_NEW;
      n.old_identity = 0;
      send_beat(n);
      n = '1;
      send_beat(n);
      send_beat(make_rec(CMD_LOAD_NEW, 8'd3, 64'd2, 64'd0));
      repeat (5) send_beat(fetch_beat());
      send_beat(fetch_beat());
   endtask

   task automatic test_invalid_sets();
      send_beat(make_rec(CMD_LOAD_OLD, 8'd1, 64'd9, 64'd0));
      send_beat(fetch_beat());
      send_beat(make_rec(CMD_LOAD_OLD, 8'd1, 64'd9, 64'd4));
      send_beat(make_rec(CMD_LOAD_OLD, 8'd1, 64'd9, 64'd5));
      send_beat(fetch_beat());
      send_beat(make_rec(CMD_LOAD_NEW, 8'd2, 64'd3, 64'd1));
      send_beat(fetch_beat());
      send_beat(make_rec(CMD_LOAD_NEW, 8'd2, 64'd0, 64'd0));
      send_beat(fetch_beat());
   endtask

   task automatic test_store_full();
      for (int i = 0; i <= MAX_NEW; i++)
         send_beat(make_rec(CMD_LOAD_NEW, 8'($urandom_range(3)), 64'd1 + i, 64'd0));
      for (int i = 0; i <= MAX_OLD; i++)
         send_beat(make_rec(CMD_LOAD_OLD, 8'd0, 64'd1 + i, r64() | 64'd1));
   endtask

   task automatic random_session();
      req_type pool [$];
      req_type b;
      int n_old, n_new, n_fetch;
      n_old = $urandom_range(0, 10);
      n_new = $urandom_range(0, 10);
      for (int i = 0; i < n_old; i++) begin
         b = make_rec(CMD_LOAD_OLD, 8'($urandom_range(3)), $urandom_range(1, 60),
                      ($urandom_range(15) == 0) ? 64'hffff_ffff_ffff_fff0 + i : r64() | 64'd1);
         if ($urandom_range(7) == 0) b.level = 8'($urandom);
         if ($urandom_range(4) == 0) b.macro_env_hash = 0;
         if ($urandom_range(40) == 0) b.old_identity = 0;
         if ($urandom_range(40) == 0) b.locator = 0;
         if ($urandom_range(50) == 0) b.body_hash = 0;
         if ($urandom_range(50) == 0) b.deps_hash = 0;
         pool.push_back(b);
         send_beat(b);
      end
      pool.shuffle();
      for (int i = 0; i < n_new; i++) begin
         if (i < pool.size() && $urandom_range(9) < 8) begin
            b = pool[i];
            case ($urandom_range(9))
               0: b.body_hash ^= 64'd1 << $urandom_range(63);
               1: b.deps_hash = r64();
               2: b.macro_flag = ~b.macro_flag;
               3: b.template_env_hash = r64();
               4: b.macro_env_hash = r64();
               default: ;
            endcase
         end else begin
            b = make_rec(CMD_LOAD_NEW, 8'($urandom_range(3)), $urandom_range(1, 60), 64'd0);
         end
         b.command = CMD_LOAD_NEW;
         b.old_identity = ($urandom_range(50) == 0) ? r64() : 64'd0;
         if ($urandom_range(50) == 0) b.body_hash = 0;
         send_beat(b);
      end
      n_fetch = n_new + 1;
      for (int i = 0; i < n_fetch; i++) begin
         if ($urandom_range(30) == 0) begin
            b = '0;
            b.command = CMD_UNUSED;
            b.locator = r64();
            send_beat(b);
         end
         if ($urandom_range(12) == 0) begin
            b = make_rec(2'($urandom_range(1)), 8'($urandom_range(3)),
                         $urandom_range(1, 60), 64'd0);
            if (b.command == CMD_LOAD_OLD) b.old_identity = r64() | 64'd1;
            send_beat(b);
            n_fetch++;
         end
         send_beat(fetch_beat());
      end
   endtask

   task automatic test_random(input int target);
      int stop_at;
      stop_at = beats_sent + target;
      while (beats_sent < stop_at) random_session();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      cycles = 0;
      fails = 0;
      beats_sent = 0;
      clear_session();
      send_idle = 33;
      recv_idle = 75;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reuse_outcomes();
      test_invalid_sets();
      drain();
      test_store_full();
      test_random(100);
      drain();
      send_idle = 75;
      recv_idle = 33;
      test_random(220);
      drain();
      send_idle = 0;
      recv_idle = 0;
      test_random(220);
      drain();
      $display("sent %0d beats: %0d accepted, %0d records, %0d counts", beats_sent,
               seen_kind[KIND_ACCEPTED], seen_kind[KIND_RECORD], seen_kind[KIND_COUNTS]);
      $display("session ends: %0d old invalid, %0d new invalid, %0d full",
               seen_kind[KIND_OLD_BAD], seen_kind[KIND_NEW_BAD], seen_kind[KIND_FULL]);
      if (fails == 0)
         $display("** keyed_identity_reuse_matcher: PASSED **");
      else
         $display("** keyed_identity_reuse_matcher: FAILED **");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+sv
sv/kirm_pkg.sv
sv/kirm_ram.sv
sv/keyed_identity_reuse_matcher.sv
dv/keyed_identity_reuse_matcher_test.sv
